// ===== sv/btpm_pkg.sv =====
// Shared types and constants for the binary trie prefix match engine.
package btpm_pkg;

  // Trie geometry
  localparam int unsigned NodeCount = 4096;
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned NodeW     = $clog2(NodeCount);
  localparam int unsigned UsedW     = NodeW + 1;
  localparam int unsigned BitPosW   = $clog2(AddrBits);

  // Field widths
  localparam int unsigned LenW = 6;
  localparam int unsigned NumW = 32;

  // Command queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdLookup = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [AddrBits-1:0] addr;
    logic [LenW-1:0]     plen;
    logic [NumW-1:0]     num;
  } item_t;

  typedef logic [1:0][NodeW-1:0] links_t;

  typedef struct packed {
    logic            valid;
    logic [NumW-1:0] num;
  } entry_t;

  typedef struct packed {
    logic            match_found;
    logic [NumW-1:0] matched_number;
    logic [LenW-1:0] matched_length;
    logic            table_full;
  } result_t;

endpackage

// ===== sv/binary_trie_prefix_match.sv =====
// Top level of the IPv4 longest-prefix-match engine on a binary trie.
//
// A transaction is taken when start_i is high and busy_o is low; busy_o rises
// only while the two-entry command queue is full. The walk engine handles one
// command at a time: it picks the command up, then walks the trie level by
// level, and each existing node below the root costs one read of the node pool
// memory. A lookup walks at most down a full /32 path, and an insert walks down
// to its prefix length unless the pool runs out. Each command yields exactly one
// result, shown for a single cycle with result_valid_o, registered and raised in
// the cycle after the walk ends; the receiver cannot hold it off and must take
// it then. Results come back in command order. The pool holds 4096 nodes, the
// root included, and needs no clearing pass after reset.
module binary_trie_prefix_match
  import btpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            command_i,
  input  logic [31:0]     address_i,
  input  logic [LenW-1:0] prefix_length_i,
  input  logic [NumW-1:0] as_number_i,
  output logic            result_valid_o,
  output logic            match_found_o,
  output logic [NumW-1:0] matched_number_o,
  output logic [LenW-1:0] matched_length_o,
  output logic            table_full_o
);

  item_t   item;
  logic    item_valid;
  logic    pop;
  result_t result;

  btpm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .address_i       (address_i),
    .prefix_length_i (prefix_length_i),
    .as_number_i     (as_number_i),
    .pop_i           (pop),
    .item_o          (item),
    .item_valid_o    (item_valid)
  );

  btpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result)
  );

  assign match_found_o    = result.match_found;
  assign matched_number_o = result.matched_number;
  assign matched_length_o = result.matched_length;
  assign table_full_o     = result.table_full;

endmodule

// ===== sv/btpm_queue.sv =====
// Small FIFO of classified commands between the front and the walk engine.
module btpm_queue
  import btpm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t            store_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == QCntW'(QDepth));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = store_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold payload in the slot at the write pointer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/btpm_front.sv =====
// Command intake: accepts transactions, normalizes fields and queues them.
module btpm_front
  import btpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            command_i,
  input  logic [31:0]     address_i,
  input  logic [LenW-1:0] prefix_length_i,
  input  logic [NumW-1:0] as_number_i,
  input  logic            pop_i,
  output item_t           item_o,
  output logic            item_valid_o
);

  item_t item_in;
  logic  full, empty, accept;

  assign busy_o = full;
  assign accept = start_i && !full;

  // Classify the command, keep the used address bits, clamp the prefix length
  always_comb begin
    item_in.cmd  = command_i ? CmdLookup : CmdInsert;
    item_in.addr = address_i[AddrBits-1:0];
    item_in.plen = (prefix_length_i > LenW'(AddrBits)) ? LenW'(AddrBits) : prefix_length_i;
    item_in.num  = as_number_i;
  end

  btpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (item_in),
    .pop_i       (pop_i),
    .pop_item_o  (item_o),
    .empty_o     (empty),
    .full_o      (full)
  );

  assign item_valid_o = !empty;

endmodule

// ===== sv/btpm_back.sv =====
// Trie walk engine: node pool memories, insert allocation and lookup search.
module btpm_back
  import btpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    item_valid_i,
  output logic    pop_o,
  output logic    result_valid_o,
  output result_t result_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWalk = 2'b10
  } state_e;

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic [NodeW-1:0]  cur_q, cur_d;
  logic              fresh_q, fresh_d;
  logic [LenW-1:0]   depth_q, depth_d;
  logic              best_found_q, best_found_d;
  logic [NumW-1:0]   best_num_q, best_num_d;
  logic [LenW-1:0]   best_len_q, best_len_d;
  logic [UsedW-1:0]  nodes_used_q, nodes_used_d;
  links_t            root_links_q, root_links_d;
  entry_t            root_entry_q, root_entry_d;
  result_t           res_q, res_d;
  logic              res_valid_q, res_valid_d;

  // Node pool; the root lives in flops, so no entry is read before it is written
  links_t            link_mem [NodeCount];
  entry_t            entry_mem [NodeCount];
  links_t            link_rdata_q;
  entry_t            entry_rdata_q;
  logic              mem_re;
  logic [NodeW-1:0]  mem_raddr;
  logic              link_we;
  logic [NodeW-1:0]  link_waddr;
  links_t            link_wdata;
  logic              entry_we;
  logic [NodeW-1:0]  entry_waddr;
  entry_t            entry_wdata;

  logic              cur_root;
  links_t            links_cur, links_upd;
  entry_t            entry_cur;
  logic [BitPosW-1:0] bit_pos;
  logic              dir;
  logic [NodeW-1:0]  next_node;

  assign cur_root  = (cur_q == '0);
  assign links_cur = cur_root ? root_links_q : (fresh_q ? '0 : link_rdata_q);
  assign entry_cur = cur_root ? root_entry_q : (fresh_q ? '0 : entry_rdata_q);
  assign bit_pos   = BitPosW'(AddrBits - 1) - depth_q[BitPosW-1:0];
  assign dir       = item_q.addr[bit_pos];
  assign next_node = links_cur[dir];

  always_comb begin
    links_upd      = links_cur;
    links_upd[dir] = nodes_used_q[NodeW-1:0];
  end

  // Walk one trie level per cycle
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cur_d        = cur_q;
    fresh_d      = fresh_q;
    depth_d      = depth_q;
    best_found_d = best_found_q;
    best_num_d   = best_num_q;
    best_len_d   = best_len_q;
    nodes_used_d = nodes_used_q;
    root_links_d = root_links_q;
    root_entry_d = root_entry_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    pop_o        = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = next_node;
    link_we      = 1'b0;
    link_waddr   = cur_q;
    link_wdata   = '0;
    entry_we     = 1'b0;
    entry_waddr  = cur_q;
    entry_wdata  = '0;

    unique case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          pop_o        = 1'b1;
          item_d       = item_i;
          cur_d        = '0;
          fresh_d      = 1'b0;
          depth_d      = '0;
          best_found_d = 1'b0;
          best_num_d   = '0;
          best_len_d   = '0;
          state_d      = StWalk;
        end
      end
      StWalk: begin
        if (item_q.cmd == CmdLookup) begin
          // Record the deepest stored entry seen so far
          if (entry_cur.valid) begin
            best_found_d = 1'b1;
            best_num_d   = entry_cur.num;
            best_len_d   = depth_q;
          end
          if (depth_q == LenW'(AddrBits) || next_node == '0) begin
            res_d.match_found    = best_found_d;
            res_d.matched_number = best_num_d;
            res_d.matched_length = best_len_d;
            res_d.table_full     = 1'b0;
            res_valid_d          = 1'b1;
            state_d              = StIdle;
          end else begin
            mem_re  = 1'b1;
            cur_d   = next_node;
            depth_d = depth_q + 1'b1;
          end
        end else begin
          if (depth_q == item_q.plen) begin
            // Store the number; a fresh end node also gets empty links
            if (cur_root) begin
              root_entry_d = '{valid: 1'b1, num: item_q.num};
            end else begin
              entry_we    = 1'b1;
              entry_wdata = '{valid: 1'b1, num: item_q.num};
            end
            link_we     = fresh_q;
            res_d       = '0;
            res_valid_d = 1'b1;
            state_d     = StIdle;
          end else if (next_node != '0) begin
            mem_re  = 1'b1;
            cur_d   = next_node;
            depth_d = depth_q + 1'b1;
          end else if (nodes_used_q == UsedW'(NodeCount)) begin
            // Pool exhausted: drop the entry, close off the last fresh node
            link_we          = fresh_q;
            res_d            = '0;
            res_d.table_full = 1'b1;
            res_valid_d      = 1'b1;
            state_d          = StIdle;
          end else begin
            // Allocate a child and link it in
            if (cur_root) begin
              root_links_d = links_upd;
            end else begin
              link_we    = 1'b1;
              link_wdata = links_upd;
            end
            entry_we     = 1'b1;
            entry_waddr  = nodes_used_q[NodeW-1:0];
            entry_wdata  = '0;
            nodes_used_d = nodes_used_q + 1'b1;
            cur_d        = nodes_used_q[NodeW-1:0];
            fresh_d      = 1'b1;
            depth_d      = depth_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      nodes_used_q <= UsedW'(1);
      root_links_q <= '0;
      root_entry_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      nodes_used_q <= nodes_used_d;
      root_links_q <= root_links_d;
      root_entry_q <= root_entry_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cur_q        <= cur_d;
    fresh_q      <= fresh_d;
    depth_q      <= depth_d;
    best_found_q <= best_found_d;
    best_num_q   <= best_num_d;
    best_len_q   <= best_len_d;
    res_q        <= res_d;
  end

  // Child link memory
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (mem_re) begin
      link_rdata_q <= link_mem[mem_raddr];
    end
  end

  // Node entry memory
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (mem_re) begin
      entry_rdata_q <= entry_mem[mem_raddr];
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
